// ===== src/elsp_pkg.sv =====
// Package for the event log stream parser: payload types, phase codes and constants.
`default_nettype none

package elsp_pkg;

	typedef enum logic [2:0] {
		PH_HEAD    = 3'd0,
		PH_RECORD  = 3'd1,
		PH_MESSAGE = 3'd2,
		PH_DONE    = 3'd3,
		PH_ERROR   = 3'd4
	} phase_t;

	localparam logic [1:0] KIND_MESSAGE = 2'd0;
	localparam logic [1:0] KIND_COMMIT  = 2'd1;
	localparam logic [1:0] KIND_STATUS  = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BADSIG = 2'd1;
	localparam logic [1:0] ST_TRUNC  = 2'd2;

	localparam logic [7:0] SIG_FIRST  = 8'h4C;
	localparam logic [7:0] SIG_SECOND = 8'h47;

	// Positions of the final byte of the stream header (4 bytes) and record header (13 bytes).
	localparam logic [3:0] STREAM_HEADER_LAST = 4'd3;
	localparam logic [3:0] RECORD_HEADER_LAST = 4'd12;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_stream;
	} in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] rec_id;
		logic [31:0] rec_time;
		logic [7:0]  level;
		logic [15:0] rec_source;
		logic [15:0] message_length;
		logic [7:0]  message_byte;
		logic        last_of_message;
		logic [1:0]  stream_status;
		logic        last_of_run;
	} out_t;

endpackage

`default_nettype wire

// ===== src/event_log_stream_parser_core.sv =====
// Top level of the event log stream parser: byte parser and three-entry result queue.
`default_nettype none

// Parses a byte stream with a two-byte signature, a 16-bit event count and records of a
// 13-byte header followed by message bytes. Each accepted byte is parsed in the cycle of its
// transfer and yields zero to three results (message byte, event commit, stream status),
// which are held in a three-entry queue and delivered one per cycle. A byte may be
// transferred in every cycle while each byte gives at most one result, so message bytes
// stream at one per clock; a byte that gives more than one result stalls the input while the
// queue drains one entry per cycle, as the queue takes a new byte once at most its last entry
// remains and that entry is leaving. Stalls on the result side add to this.
// After the end-of-stream byte the parser is back in its reset state, ready for the next
// stream.
module event_log_stream_parser_core (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              byte_valid,
	output logic             byte_stall,
	input  elsp_pkg::in_t    byte_data,
	output logic             result_valid,
	input  wire              result_stall,
	output elsp_pkg::out_t   result_data
);

	elsp_pkg::phase_t phase_q, n_phase;
	logic [3:0]  pos_q, n_pos;
	logic [15:0] events_q, n_events, events_dec;
	logic [15:0] msg_rem_q, n_msg_rem;
	logic [31:0] id_q, n_id;
	logic [31:0] time_q, n_time;
	logic [7:0]  level_q, n_level;
	logic [15:0] source_q, n_source;
	logic [15:0] length_q, n_length;
	logic [1:0]  err_q, n_err;

	logic        has_msg, has_commit, has_status, last_msg, do_commit;
	logic [1:0]  status_v;
	logic [1:0]  run_cnt;
	elsp_pkg::out_t run_r [3];

	elsp_pkg::out_t slot_q [3];
	logic [1:0]  cnt_q;
	logic        accept, pop;
	logic [7:0]  b;

	assign b            = byte_data.in_byte;
	assign result_valid = (cnt_q != 2'd0);
	assign result_data  = slot_q[0];
	assign pop          = result_valid && !result_stall;
	assign byte_stall   = !((cnt_q == 2'd0) || ((cnt_q == 2'd1) && !result_stall));
	assign accept       = byte_valid && !byte_stall;
	// A commit only happens in the record and message phases, where the count is unchanged.
	assign events_dec   = events_q - 16'd1;

	always_comb begin
		n_phase    = phase_q;
		n_pos      = pos_q;
		n_events   = events_q;
		n_msg_rem  = msg_rem_q;
		n_id       = id_q;
		n_time     = time_q;
		n_level    = level_q;
		n_source   = source_q;
		n_length   = length_q;
		n_err      = err_q;
		has_msg    = 1'b0;
		has_commit = 1'b0;
		has_status = 1'b0;
		last_msg   = 1'b0;
		do_commit  = 1'b0;
		status_v   = elsp_pkg::ST_OK;

		case (phase_q)
			elsp_pkg::PH_HEAD: begin
				if ((pos_q == 4'd0 && b != elsp_pkg::SIG_FIRST) ||
				    (pos_q == 4'd1 && b != elsp_pkg::SIG_SECOND)) begin
					n_err = elsp_pkg::ST_BADSIG;
				end
				if (pos_q >= 4'd2) begin
					n_events = {events_q[7:0], b};
				end
				if (pos_q >= elsp_pkg::STREAM_HEADER_LAST) begin
					n_pos = 4'd0;
					if (n_err != elsp_pkg::ST_OK) begin
						n_phase = elsp_pkg::PH_ERROR;
					end else if (n_events == 16'd0) begin
						n_phase = elsp_pkg::PH_DONE;
					end else begin
						n_phase = elsp_pkg::PH_RECORD;
					end
				end else begin
					n_pos = pos_q + 4'd1;
				end
			end
			elsp_pkg::PH_RECORD: begin
				if (pos_q < 4'd4) begin
					n_id = {id_q[23:0], b};
				end else if (pos_q < 4'd8) begin
					n_time = {time_q[23:0], b};
				end else if (pos_q == 4'd8) begin
					n_level = b;
				end else if (pos_q < 4'd11) begin
					n_source = {source_q[7:0], b};
				end else begin
					n_length = {length_q[7:0], b};
				end
				if (pos_q >= elsp_pkg::RECORD_HEADER_LAST) begin
					n_pos = 4'd0;
					if (n_length == 16'd0) begin
						do_commit = 1'b1;
					end else begin
						n_msg_rem = n_length;
						n_phase   = elsp_pkg::PH_MESSAGE;
					end
				end else begin
					n_pos = pos_q + 4'd1;
				end
			end
			elsp_pkg::PH_MESSAGE: begin
				has_msg   = 1'b1;
				last_msg  = (msg_rem_q <= 16'd1);
				n_msg_rem = msg_rem_q - 16'd1;
				do_commit = last_msg;
			end
			default: begin
			end
		endcase

		if (do_commit) begin
			has_commit = 1'b1;
			n_events   = events_dec;
			n_phase    = (events_dec == 16'd0) ? elsp_pkg::PH_DONE : elsp_pkg::PH_RECORD;
			n_pos      = 4'd0;
		end

		// The commit and status results are built from the values before the end-of-stream
		// return to reset below.
		for (int i = 0; i < 3; i++) begin
			run_r[i] = '0;
		end
		run_cnt = 2'd0;
		if (has_msg) begin
			run_r[run_cnt].kind            = elsp_pkg::KIND_MESSAGE;
			run_r[run_cnt].message_length  = length_q;
			run_r[run_cnt].message_byte    = b;
			run_r[run_cnt].last_of_message = last_msg;
			run_cnt = run_cnt + 2'd1;
		end
		if (has_commit) begin
			run_r[run_cnt].kind           = elsp_pkg::KIND_COMMIT;
			run_r[run_cnt].rec_id         = n_id;
			run_r[run_cnt].rec_time       = n_time;
			run_r[run_cnt].level          = n_level;
			run_r[run_cnt].rec_source     = n_source;
			run_r[run_cnt].message_length = n_length;
			run_cnt = run_cnt + 2'd1;
		end

		if (byte_data.end_of_stream) begin
			has_status = 1'b1;
			if (n_phase == elsp_pkg::PH_HEAD) begin
				status_v = elsp_pkg::ST_TRUNC;
			end else if (n_err != elsp_pkg::ST_OK) begin
				status_v = n_err;
			end else if (n_phase == elsp_pkg::PH_DONE) begin
				status_v = elsp_pkg::ST_OK;
			end else if (n_phase == elsp_pkg::PH_RECORD || n_phase == elsp_pkg::PH_MESSAGE) begin
				status_v = elsp_pkg::ST_TRUNC;
			end else begin
				status_v = elsp_pkg::ST_BADSIG;
			end
			n_phase   = elsp_pkg::PH_HEAD;
			n_pos     = 4'd0;
			n_events  = 16'd0;
			n_msg_rem = 16'd0;
			n_id      = 32'd0;
			n_time    = 32'd0;
			n_level   = 8'd0;
			n_source  = 16'd0;
			n_length  = 16'd0;
			n_err     = elsp_pkg::ST_OK;
		end
		if (has_status) begin
			run_r[run_cnt].kind          = elsp_pkg::KIND_STATUS;
			run_r[run_cnt].stream_status = status_v;
			run_cnt = run_cnt + 2'd1;
		end
		if (run_cnt != 2'd0) begin
			run_r[run_cnt - 2'd1].last_of_run = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= elsp_pkg::PH_HEAD;
			pos_q     <= 4'd0;
			events_q  <= 16'd0;
			msg_rem_q <= 16'd0;
			id_q      <= 32'd0;
			time_q    <= 32'd0;
			level_q   <= 8'd0;
			source_q  <= 16'd0;
			length_q  <= 16'd0;
			err_q     <= elsp_pkg::ST_OK;
		end else if (accept) begin
			phase_q   <= n_phase;
			pos_q     <= n_pos;
			events_q  <= n_events;
			msg_rem_q <= n_msg_rem;
			id_q      <= n_id;
			time_q    <= n_time;
			level_q   <= n_level;
			source_q  <= n_source;
			length_q  <= n_length;
			err_q     <= n_err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (accept) begin
			cnt_q <= run_cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// A byte is taken only when the queue is empty after this cycle, so a new run replaces it.
	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q[0] <= run_r[0];
			slot_q[1] <= run_r[1];
			slot_q[2] <= run_r[2];
		end else if (pop) begin
			slot_q[0] <= slot_q[1];
			slot_q[1] <= slot_q[2];
		end
	end

endmodule

`default_nettype wire

// ===== src/elsp_checker.sv =====
// Port-level checker for the event log stream parser, bound to the top level.
`default_nettype none

module elsp_checker (
	input wire            clk,
	input wire            arst_n,
	input wire            byte_stall,
	input wire            result_valid,
	input wire            result_stall,
	input elsp_pkg::out_t result_data
);

	// A stalled result holds.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_data))
		else $error("stalled result changed or was withdrawn");

	// The rest of a run is already queued, so it follows without a gap.
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !result_data.last_of_run |=> result_valid)
		else $error("gap inside a run of results");

	// While more than the final result of a run waits, no new byte is taken.
	a_input_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_data.last_of_run |-> byte_stall)
		else $error("byte taken while a run was still queued");

	// A status always closes its run.
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.kind == elsp_pkg::KIND_STATUS |-> result_data.last_of_run)
		else $error("stream status is not the final result of its byte");

	// Record id, time and source are zero except on a commit.
	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.kind != elsp_pkg::KIND_COMMIT |->
		result_data.rec_id == 32'd0 && result_data.rec_time == 32'd0 &&
		result_data.rec_source == 16'd0)
		else $error("record fields set on a result that is not a commit");

endmodule

bind event_log_stream_parser_core elsp_checker u_elsp_checker (.*);

`default_nettype wire
